### rtl/core/tcbd_pkg.sv
package tcbd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [10:0] DIM_RESET = 11'd8;

    // Two-entry job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 683 / 2048 is close enough to 1/3 for every sum below 1536.
    localparam logic [9:0] RECIP3 = 10'd683;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    typedef struct packed {
        t_rgba [3:0]  pal;
        logic  [31:0] idx;
        logic  [15:0] mask;
        logic  [9:0]  base_x;
        logic  [9:0]  base_y;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic load;
        logic last;
        logic mask_nz;
    } t_back_stat;

    function automatic logic [7:0] grow5(input logic [4:0] v);
        grow5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] grow6(input logic [5:0] v);
        grow6 = {v, v[5:4]};
    endfunction

    // Truncated (2a + b) / 3 for 8-bit a and b.
    function automatic logic [7:0] third(input logic [7:0] a, input logic [7:0] b);
        logic [9:0]  s;
        logic [19:0] p;
        s = {1'b0, a, 1'b0} + {2'b00, b};
        p = s * RECIP3;
        third = p[18:11];
    endfunction

    function automatic logic [7:0] midpoint(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        midpoint = s[8:1];
    endfunction

endpackage

### rtl/core/tiled_cmpr_block_decoder_core.sv
// Tiled BC1 block decoder.
// Input channel (i_valid / o_ready, i_block_word): one beat per 8-byte compressed
// 4x4 sub-block, color0 in bits 63:48, color1 in 47:32, indices in 31:0.
// Sub-blocks arrive four per 8x8 macro tile (top-left, top-right, bottom-left,
// bottom-right), tiles row-major; the position wraps after the last tile.
// Output channel (o_valid / i_ready): one beat per visible texel with its image
// coordinates and RGBA8 color; o_last_of_block marks the final texel of a block.
// Texels outside image_width x image_height are dropped, and a fully clipped
// block produces no beat at all.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// width, index 1 the height; write them only while the block is idle.
// An accepted block is written into the queue, and the back loads each visible texel
// of the queue head into the output register; clipped positions before the first
// visible texel are passed over first. Throughput: the texel sequencer visits one
// texel position per cycle while the output slot is free or the position is clipped,
// up to the block's last visible one.
// A two-entry queue buffers decoded blocks, so input is taken while the output
// stalls, until the queue is full. Reset sets both dimensions to 8, the position
// to the first sub-block, and empties the queue and output register.
module tiled_cmpr_block_decoder_core #(
    parameter int MAX_DIM = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_texel_x,
    output logic [9:0]  o_texel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_last_of_block
);

    logic                 push;
    logic                 pop;
    tcbd_pkg::t_job       job;
    tcbd_pkg::t_job       head;
    tcbd_pkg::t_q_stat    q_stat;
    tcbd_pkg::t_back_stat b_stat;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !q_stat.full;

    tcbd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_block_word (i_block_word),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_job        (job)
    );

    tcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tcbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (q_stat.valid),
        .i_ready         (i_ready),
        .o_pop           (pop),
        .o_stat          (b_stat),
        .o_valid         (o_valid),
        .o_texel_x       (o_texel_x),
        .o_texel_y       (o_texel_y),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_alpha         (o_alpha),
        .o_last_of_block (o_last_of_block)
    );

`ifndef SYNTHESIS
    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("block pushed into a full queue");

    // The back only pops from a non-empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.valid)
        else $error("pop from an empty queue");

    // A block with visible texels retires exactly when its last texel is loaded.
    a_retire_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.pop && b_stat.mask_nz |-> b_stat.load && b_stat.last)
        else $error("block retired without emitting its last texel");

    // Reset empties the queue and the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !q_stat.valid)
        else $error("state not cleared by reset");
`endif

endmodule

### rtl/core/tcbd_front.sv
module tcbd_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    input  logic              i_valid,
    input  logic [63:0]       i_block_word,
    input  tcbd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output tcbd_pkg::t_job    o_job
);

    localparam int EFF_MAX  = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
    localparam int TILE_MAX = (EFF_MAX + 7) / 8;
    localparam int TW       = (TILE_MAX > 1) ? $clog2(TILE_MAX) : 1;
    localparam logic [10:0] DIM_CAP = 11'(EFF_MAX);

    logic [10:0]   r_width;
    logic [10:0]   r_height;
    logic [TW-1:0] r_col;
    logic [TW-1:0] r_row;
    logic [1:0]    r_sub;
    logic [TW-1:0] n_col;
    logic [TW-1:0] n_row;
    logic [1:0]    n_sub;

    logic [10:0] eff_w;
    logic [10:0] eff_h;
    logic [11:0] sum_w;
    logic [11:0] sum_h;
    logic [8:0]  tiles_w;
    logic [8:0]  tiles_h;
    logic [8:0]  col_inc;
    logic [8:0]  row_inc;

    logic [15:0]    c0;
    logic [15:0]    c1;
    tcbd_pkg::t_rgba e0;
    tcbd_pkg::t_rgba e1;
    tcbd_pkg::t_rgba e2;
    tcbd_pkg::t_rgba e3;
    logic [3:0]     col_ok;
    logic [3:0]     row_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= tcbd_pkg::DIM_RESET;
            r_height <= tcbd_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tcbd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                tcbd_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_w   = (r_width > DIM_CAP) ? DIM_CAP : r_width;
    assign eff_h   = (r_height > DIM_CAP) ? DIM_CAP : r_height;
    assign sum_w   = {1'b0, eff_w} + 12'd7;
    assign sum_h   = {1'b0, eff_h} + 12'd7;
    // A zero dimension still counts as one macro tile.
    assign tiles_w = (sum_w[11:3] == 9'd0) ? 9'd1 : sum_w[11:3];
    assign tiles_h = (sum_h[11:3] == 9'd0) ? 9'd1 : sum_h[11:3];
    assign col_inc = 9'(r_col) + 9'd1;
    assign row_inc = 9'(r_row) + 9'd1;

    assign o_push = i_valid && !i_q_stat.full;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_sub = r_sub + 2'd1;
        if (r_sub == 2'd3) begin
            if (col_inc >= tiles_w) begin
                n_col = '0;
                n_row = (row_inc >= tiles_h) ? '0 : row_inc[TW-1:0];
            end else begin
                n_col = col_inc[TW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_sub <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
            r_sub <= n_sub;
        end
    end

    // Palette.
    assign c0 = i_block_word[63:48];
    assign c1 = i_block_word[47:32];

    always_comb begin
        e0 = '{red: tcbd_pkg::grow5(c0[15:11]), green: tcbd_pkg::grow6(c0[10:5]),
               blue: tcbd_pkg::grow5(c0[4:0]), alpha: 8'hFF};
        e1 = '{red: tcbd_pkg::grow5(c1[15:11]), green: tcbd_pkg::grow6(c1[10:5]),
               blue: tcbd_pkg::grow5(c1[4:0]), alpha: 8'hFF};
        if (c0 > c1) begin
            e2 = '{red: tcbd_pkg::third(e0.red, e1.red),
                   green: tcbd_pkg::third(e0.green, e1.green),
                   blue: tcbd_pkg::third(e0.blue, e1.blue), alpha: 8'hFF};
            e3 = '{red: tcbd_pkg::third(e1.red, e0.red),
                   green: tcbd_pkg::third(e1.green, e0.green),
                   blue: tcbd_pkg::third(e1.blue, e0.blue), alpha: 8'hFF};
        end else begin
            e2 = '{red: tcbd_pkg::midpoint(e0.red, e1.red),
                   green: tcbd_pkg::midpoint(e0.green, e1.green),
                   blue: tcbd_pkg::midpoint(e0.blue, e1.blue), alpha: 8'hFF};
            e3 = '0;
        end
    end

    // Clipping mask: texel i is visible when its column and its row both are.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            col_ok[j] = 12'({r_col, r_sub[0], 2'(j)}) < {1'b0, eff_w};
            row_ok[j] = 12'({r_row, r_sub[1], 2'(j)}) < {1'b0, eff_h};
        end
        for (int i = 0; i < 16; i++) begin
            o_job.mask[i] = col_ok[i % 4] && row_ok[i / 4];
        end
        o_job.pal    = {e3, e2, e1, e0};
        o_job.idx    = i_block_word[31:0];
        o_job.base_x = 10'({r_col, r_sub[0], 2'b00});
        o_job.base_y = 10'({r_row, r_sub[1], 2'b00});
    end

endmodule

### rtl/core/tcbd_queue.sv
module tcbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcbd_pkg::t_job    i_job,
    input  logic              i_pop,
    output tcbd_pkg::t_job    o_head,
    output tcbd_pkg::t_q_stat o_stat
);

    tcbd_pkg::t_job                   r_mem [tcbd_pkg::QUEUE_DEPTH];
    logic [tcbd_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [tcbd_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [tcbd_pkg::QCNT_W-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == tcbd_pkg::QCNT_W'(tcbd_pkg::QUEUE_DEPTH));

endmodule

### rtl/core/tcbd_back.sv
module tcbd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcbd_pkg::t_job       i_head,
    input  logic                 i_head_valid,
    input  logic                 i_ready,
    output logic                 o_pop,
    output tcbd_pkg::t_back_stat o_stat,
    output logic                 o_valid,
    output logic [9:0]           o_texel_x,
    output logic [9:0]           o_texel_y,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [7:0]           o_alpha,
    output logic                 o_last_of_block
);

    logic [3:0]      r_pos;
    logic            r_valid;
    logic [15:0]     rest;
    logic            cur;
    logic            higher;
    logic            slot_free;
    logic            step;
    logic            load;
    logic [4:0]      shamt;
    logic [1:0]      code;
    tcbd_pkg::t_rgba color;

    assign rest      = i_head.mask >> r_pos;
    assign cur       = rest[0];
    assign higher    = |rest[15:1];
    assign slot_free = !r_valid || i_ready;
    // Clipped positions are passed over without waiting for the output slot.
    assign step      = i_head_valid && (slot_free || !cur);
    assign load      = step && cur;
    assign o_pop     = step && !higher;

    assign shamt = 5'd30 - {r_pos, 1'b0};
    assign code  = 2'(i_head.idx >> shamt);
    assign color = i_head.pal[code];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_pos <= higher ? r_pos + 4'd1 : 4'd0;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_texel_x       <= i_head.base_x | {8'd0, r_pos[1:0]};
            o_texel_y       <= i_head.base_y | {8'd0, r_pos[3:2]};
            o_red           <= color.red;
            o_green         <= color.green;
            o_blue          <= color.blue;
            o_alpha         <= color.alpha;
            o_last_of_block <= !higher;
        end
    end

    assign o_valid        = r_valid;
    assign o_stat.pop     = o_pop;
    assign o_stat.load    = load;
    assign o_stat.last    = !higher;
    assign o_stat.mask_nz = (i_head.mask != 16'd0);

endmodule
